FILE: design/mpha_pkg.sv
// Shared constants, side-band type and arctangent table for the marker pair heading block.
// No dependencies; used by every module of the block.
package mpha_pkg;

	localparam int FIELD_BITS       = 12;
	localparam int OUT_BITS         = 16;
	localparam int ANG_FRAC         = 24;
	localparam int TABLE_LEN        = 24;
	localparam int ZW               = 34;
	localparam int ZC_BITS          = 31;
	localparam int PROD_BITS        = 38;
	localparam int CDEG_BITS        = 14;
	localparam int COORD_BITS_DEF   = 12;
	localparam int CORDIC_STEPS_DEF = 18;

	localparam logic [ZC_BITS-1:0]   DEG90_Q   = ZC_BITS'(90) << ANG_FRAC;
	localparam logic [6:0]           DEG_SCALE = 7'd100;
	localparam logic [OUT_BITS-1:0]  HALF_TURN = 16'd18000;
	localparam logic [OUT_BITS-1:0]  QTR_TURN  = 16'd9000;
	localparam logic [OUT_BITS-1:0]  ZERO_HDG  = 16'd0;

	typedef struct packed {
		logic                special;
		logic [OUT_BITS-1:0] spec_val;
		logic                dx_neg;
		logic                dy_neg;
	} mpha_side_t;

	// atan(2^-i) in degrees, Q24, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q24(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = 34'sd754974720;
			1:  v = 34'sd445687602;
			2:  v = 34'sd235489088;
			3:  v = 34'sd119537938;
			4:  v = 34'sd60000934;
			5:  v = 34'sd30029717;
			6:  v = 34'sd15018523;
			7:  v = 34'sd7509720;
			8:  v = 34'sd3754917;
			9:  v = 34'sd1877466;
			10: v = 34'sd938734;
			11: v = 34'sd469367;
			12: v = 34'sd234684;
			13: v = 34'sd117342;
			14: v = 34'sd58671;
			15: v = 34'sd29335;
			16: v = 34'sd14668;
			17: v = 34'sd7334;
			18: v = 34'sd3667;
			19: v = 34'sd1833;
			20: v = 34'sd917;
			21: v = 34'sd458;
			22: v = 34'sd229;
			23: v = 34'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/mpha_prep.sv
// Input stage: masks coordinates, forms the differences, sorts out the special cases
// and loads the CORDIC start vector. Depends on mpha_pkg.
module mpha_prep import mpha_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int XW = COORD_BITS_DEF + ANG_FRAC + 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FIELD_BITS-1:0] first_x,
	input  logic [FIELD_BITS-1:0] first_y,
	input  logic [FIELD_BITS-1:0] second_x,
	input  logic [FIELD_BITS-1:0] second_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [XW-1:0]  x_out,
	output logic signed [XW-1:0]  y_out,
	output mpha_side_t            side_out
);

	logic [CB-1:0]        fx, fy, sx, sy;
	logic signed [CB:0]   dx, dy;
	logic [CB:0]          adx_w, ady_w;
	logic                 miss;
	mpha_side_t           side_c;
	logic                 valid_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	mpha_side_t           side_s1;

	always_comb begin
		fx    = CB'(first_x);
		fy    = CB'(first_y);
		sx    = CB'(second_x);
		sy    = CB'(second_y);
		dx    = $signed({1'b0, fx}) - $signed({1'b0, sx});
		dy    = $signed({1'b0, sy}) - $signed({1'b0, fy});
		adx_w = dx[CB] ? -dx : dx;
		ady_w = dy[CB] ? -dy : dy;
		miss  = (fx == '0) || (fy == '0) || (sx == '0) || (sy == '0);
		side_c.dx_neg   = dx[CB];
		side_c.dy_neg   = dy[CB];
		side_c.special  = 1'b1;
		side_c.spec_val = ZERO_HDG;
		if (miss) begin
			side_c.spec_val = ZERO_HDG;
		end else if (dy == '0) begin
			side_c.spec_val = QTR_TURN;
		end else if (dx == '0) begin
			side_c.spec_val = dy[CB] ? HALF_TURN : ZERO_HDG;
		end else begin
			side_c.special = 1'b0;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			// start vector: x = |dy|, y = |dx|, both Q24
			x_s1    <= $signed(XW'({ady_w[CB-1:0], {ANG_FRAC{1'b0}}}));
			y_s1    <= $signed(XW'({adx_w[CB-1:0], {ANG_FRAC{1'b0}}}));
			side_s1 <= side_c;
		end
	end

	assign out_valid = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign side_out  = side_s1;

endmodule

FILE: design/mpha_cstep.sv
// One registered micro-rotation of the vectoring CORDIC, angle kept in degrees Q24.
// Depends on mpha_pkg for the arctangent table and side-band type.
module mpha_cstep import mpha_pkg::*; #(
	parameter int XW  = COORD_BITS_DEF + ANG_FRAC + 3,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  mpha_side_t           side_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output mpha_side_t           side_out
);

	localparam logic signed [ZW-1:0] ATAN_I = atan_q24(IDX);

	logic signed [XW-1:0] xs, ys, x_n, y_n;
	logic signed [ZW-1:0] z_n;
	logic                 valid_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	mpha_side_t           side_s1;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		if (!y_in[XW-1]) begin
			x_n = x_in + ys;
			y_n = y_in - xs;
			z_n = z_in + ATAN_I;
		end else begin
			x_n = x_in - ys;
			y_n = y_in + xs;
			z_n = z_in - ATAN_I;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1    <= x_n;
			y_s1    <= y_n;
			z_s1    <= z_n;
			side_s1 <= side_in;
		end
	end

	assign out_valid = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;
	assign side_out  = side_s1;

endmodule

FILE: design/mpha_post.sv
// Output end: clamps the angle, scales to centidegrees (registered product), then
// rounds, restores the quadrant and holds the result. Depends on mpha_pkg.
module mpha_post import mpha_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [ZW-1:0] z_in,
	input  mpha_side_t           side_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_BITS-1:0]  heading
);

	logic [ZC_BITS-1:0]   zc;
	logic                 valid_s1, valid_s2, ready_s2;
	logic [PROD_BITS-1:0] prod_s1;
	mpha_side_t           side_s1;
	logic [PROD_BITS-1:0] rnd;
	logic [CDEG_BITS-1:0] cdeg;
	logic [OUT_BITS-1:0]  mag, res;
	logic [OUT_BITS-1:0]  heading_s2;

	always_comb begin
		if (z_in[ZW-1]) begin
			zc = '0;
		end else if (z_in > $signed({{(ZW-ZC_BITS){1'b0}}, DEG90_Q})) begin
			zc = DEG90_Q;
		end else begin
			zc = z_in[ZC_BITS-1:0];
		end
	end

	assign in_ready = !valid_s1 || ready_s2;
	assign ready_s2 = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= PROD_BITS'(zc) * PROD_BITS'(DEG_SCALE);
			side_s1 <= side_in;
		end
	end

	always_comb begin
		// round half up to whole centidegrees
		rnd  = prod_s1 + (PROD_BITS'(1) << (ANG_FRAC - 1));
		cdeg = rnd[ANG_FRAC +: CDEG_BITS];
		mag  = side_s1.dy_neg ? HALF_TURN - OUT_BITS'(cdeg) : OUT_BITS'(cdeg);
		res  = side_s1.dx_neg ? -mag : mag;
		if (side_s1.special) begin
			res = side_s1.spec_val;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			heading_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign heading   = heading_s2;

endmodule

FILE: design/marker_pair_heading_angle.sv
// Top level of the marker pair heading block: input stage, CORDIC step chain, output end.
// Depends on mpha_pkg, mpha_prep, mpha_cstep and mpha_post.
//
//  channel | dir | payload (lowest bit first)
//  s_      | in  | tdata: first_x[11:0], first_y[23:12], second_x[35:24], second_y[47:36]
//  m_      | out | tdata: heading_centideg[15:0], signed centidegrees
//
// One item per cycle sustained while m_ takes results; the stages are
// one input stage, one stage per CORDIC micro-rotation, product stage, output register.
// Every stage has its own valid bit and takes an item whenever it is empty or its
// successor moves, so bubbles close up and a stall at m_ holds items in place.
// Reset clears all valid bits; the pipeline is empty and ready straight after.
module marker_pair_heading_angle import mpha_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [4*FIELD_BITS-1:0]   s_tdata,  // first_x, first_y, second_x, second_y
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_BITS-1:0]       m_tdata   // heading_centideg
);

	localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int XW    = COORD_BITS + ANG_FRAC + 3;

	logic                 vld [NSTEP+1];
	logic                 rdy [NSTEP+1];
	logic signed [XW-1:0] xv  [NSTEP+1];
	logic signed [XW-1:0] yv  [NSTEP+1];
	logic signed [ZW-1:0] zv  [NSTEP+1];
	mpha_side_t           sd  [NSTEP+1];

	mpha_prep #(
		.CB (COORD_BITS),
		.XW (XW)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.first_x   (s_tdata[0*FIELD_BITS +: FIELD_BITS]),
		.first_y   (s_tdata[1*FIELD_BITS +: FIELD_BITS]),
		.second_x  (s_tdata[2*FIELD_BITS +: FIELD_BITS]),
		.second_y  (s_tdata[3*FIELD_BITS +: FIELD_BITS]),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.x_out     (xv[0]),
		.y_out     (yv[0]),
		.side_out  (sd[0])
	);

	assign zv[0] = '0;

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		mpha_cstep #(
			.XW  (XW),
			.IDX (k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[k]),
			.in_ready  (rdy[k]),
			.x_in      (xv[k]),
			.y_in      (yv[k]),
			.z_in      (zv[k]),
			.side_in   (sd[k]),
			.out_valid (vld[k+1]),
			.out_ready (rdy[k+1]),
			.x_out     (xv[k+1]),
			.y_out     (yv[k+1]),
			.z_out     (zv[k+1]),
			.side_out  (sd[k+1])
		);
	end

	mpha_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[NSTEP]),
		.in_ready  (rdy[NSTEP]),
		.z_in      (zv[NSTEP]),
		.side_in   (sd[NSTEP]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.heading   (m_tdata)
	);

endmodule

FILE: design/mpha_chk.sv
// Port-level checker for the marker pair heading block, bound to the top level.
// Depends on mpha_pkg for widths.
module mpha_chk import mpha_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [4*FIELD_BITS-1:0] s_tdata,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [OUT_BITS-1:0]     m_tdata
);

	logic [7:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 8'd1;
		end
	end

	// an offered item waits unchanged until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("offered item changed before acceptance");

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= $signed(HALF_TURN)) &&
			($signed(m_tdata) >= -$signed(HALF_TURN)))
		else $error("heading out of range");

	// every result comes from an item taken earlier
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 8'd0)
		else $error("result without an item");

	// an empty output register lets the whole chain move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind marker_pair_heading_angle mpha_chk u_mpha_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/marker_pair_heading_angle_tb.sv
// Self-checking bench for marker_pair_heading_angle: streams coordinate pairs, predicts
// each heading with a CORDIC of its own and checks every result in order.
// Depends on mpha_pkg and the marker_pair_heading_angle RTL.
module marker_pair_heading_angle_tb import mpha_pkg::*; ();

	localparam int STEPS       = (CORDIC_STEPS_DEF > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS_DEF;
	localparam int LATENCY     = STEPS + 3;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 460;
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_HEAVY  = 73;
	localparam int IDLE_LIGHT  = 27;
	localparam logic [FIELD_BITS-1:0] CMAX = '1;

	typedef struct {
		logic [FIELD_BITS-1:0] fx;
		logic [FIELD_BITS-1:0] fy;
		logic [FIELD_BITS-1:0] sx;
		logic [FIELD_BITS-1:0] sy;
		int unsigned           tx_pct;
		int unsigned           rx_pct;
		bit                    drain;
		bit                    hold;
	} coord_item_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [4*FIELD_BITS-1:0]  s_tdata = '0;  // first_x, first_y, second_x, second_y
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_BITS-1:0]      m_tdata;       // heading_centideg

	coord_item_t                 coord_fifo[$];
	logic signed [OUT_BITS-1:0]  heading_expected[$];
	int                          outstanding = 0;
	int                          error_count = 0;
	int unsigned                 rx_idle_pct = IDLE_NONE;
	logic                        hold_req = 1'b0;
	logic                        hold_seen = 1'b0;
	int                          hold_left = 0;

	marker_pair_heading_angle u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic longint atan_step_q24(input int i);
		case (i)
			0:  return 754974720;
			1:  return 445687602;
			2:  return 235489088;
			3:  return 119537938;
			4:  return 60000934;
			5:  return 30029717;
			6:  return 15018523;
			7:  return 7509720;
			8:  return 3754917;
			9:  return 1877466;
			10: return 938734;
			11: return 469367;
			12: return 234684;
			13: return 117342;
			14: return 58671;
			15: return 29335;
			16: return 14668;
			17: return 7334;
			18: return 3667;
			19: return 1833;
			20: return 917;
			21: return 458;
			22: return 229;
			23: return 115;
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [OUT_BITS-1:0] heading_predict(
		input logic [4*FIELD_BITS-1:0] d
	);
		longint fx, fy, sx, sy, dx, dy, cx, cy, xs, ys, z, c;
		fx = longint'(d[FIELD_BITS-1:0]);
		fy = longint'(d[2*FIELD_BITS-1:FIELD_BITS]);
		sx = longint'(d[3*FIELD_BITS-1:2*FIELD_BITS]);
		sy = longint'(d[4*FIELD_BITS-1:3*FIELD_BITS]);
		if (fx == 0 || fy == 0 || sx == 0 || sy == 0)
			return 16'sd0;
		dx = fx - sx;
		dy = sy - fy;
		if (dy == 0)
			return 16'sd9000;
		if (dx == 0)
			return (dy < 0) ? 16'sd18000 : 16'sd0;
		// vectoring on the magnitudes, quadrant put back afterwards
		cx = ((dy < 0) ? -dy : dy) <<< ANG_FRAC;
		cy = ((dx < 0) ? -dx : dx) <<< ANG_FRAC;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy >= 0) begin
				cx = cx + ys;
				cy = cy - xs;
				z = z + atan_step_q24(i);
			end else begin
				cx = cx - ys;
				cy = cy + xs;
				z = z - atan_step_q24(i);
			end
		end
		if (z < 0)
			z = 0;
		if (z > (longint'(90) <<< ANG_FRAC))
			z = longint'(90) <<< ANG_FRAC;
		c = (z * 100 + (longint'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
		if (dy < 0)
			c = 18000 - c;
		if (dx < 0)
			c = -c;
		return c[OUT_BITS-1:0];
	endfunction

	task automatic add_item(input logic [FIELD_BITS-1:0] fx, fy, sx, sy,
			input int unsigned tx_pct, rx_pct, input bit drain, hold);
		coord_item_t it;
		it.fx = fx;
		it.fy = fy;
		it.sx = sx;
		it.sy = sy;
		it.tx_pct = tx_pct;
		it.rx_pct = rx_pct;
		it.drain = drain;
		it.hold = hold;
		coord_fifo.push_back(it);
	endtask

	function automatic logic [FIELD_BITS-1:0] clip_coord(input int v);
		if (v < 1)
			return FIELD_BITS'(1);
		if (v > int'(CMAX))
			return CMAX;
		return v[FIELD_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] edge_coord();
		case ($urandom_range(3))
			0:       return FIELD_BITS'(1);
			1:       return CMAX;
			2:       return CMAX - FIELD_BITS'(1);
			default: return FIELD_BITS'(1) << (FIELD_BITS - 1);
		endcase
	endfunction

	task automatic add_random(input int unsigned tx_pct, rx_pct, input bit drain, hold);
		logic [FIELD_BITS-1:0] fx, fy, sx, sy;
		int unsigned kind, cx, cy;
		kind = $urandom_range(99);
		fx = FIELD_BITS'($urandom_range(CMAX, 1));
		fy = FIELD_BITS'($urandom_range(CMAX, 1));
		sx = FIELD_BITS'($urandom_range(CMAX, 1));
		sy = FIELD_BITS'($urandom_range(CMAX, 1));
		if (kind < 6) begin
			// marker not found
			case ($urandom_range(3))
				0: fx = '0;
				1: fy = '0;
				2: sx = '0;
				default: sy = '0;
			endcase
		end else if (kind < 12) begin
			sy = fy;
		end else if (kind < 18) begin
			sx = fx;
		end else if (kind < 30) begin
			cx = $urandom_range(CMAX, 1);
			cy = $urandom_range(CMAX, 1);
			fx = clip_coord(int'(cx) + int'($urandom_range(6)) - 3);
			sx = clip_coord(int'(cx) + int'($urandom_range(6)) - 3);
			fy = clip_coord(int'(cy) + int'($urandom_range(6)) - 3);
			sy = clip_coord(int'(cy) + int'($urandom_range(6)) - 3);
		end else if (kind < 36) begin
			fx = edge_coord();
			fy = edge_coord();
			sx = edge_coord();
			sy = edge_coord();
		end
		add_item(fx, fy, sx, sy, tx_pct, rx_pct, drain, hold);
	endtask

	// driver: next item is put up once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (coord_fifo.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (coord_fifo[0].drain && (outstanding != 0 || (s_tvalid && s_tready))) begin
				s_tvalid <= 1'b0;
			end else if ($urandom_range(99) < coord_fifo[0].tx_pct) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {coord_fifo[0].sy, coord_fifo[0].sx,
					coord_fifo[0].fy, coord_fifo[0].fx};
				rx_idle_pct <= coord_fifo[0].rx_pct;
				if (coord_fifo[0].hold)
					hold_req <= ~hold_req;
				void'(coord_fifo.pop_front());
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: predicts on input acceptance, checks on output acceptance
	always @(posedge clk) begin : monitor
		logic signed [OUT_BITS-1:0] want;
		logic signed [OUT_BITS-1:0] got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				heading_expected.push_back(heading_predict(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (heading_expected.size() == 0) begin
					$error("heading_centideg: expected none, actual %0d", got);
					error_count++;
				end else begin
					want = heading_expected.pop_front();
					if (got !== want) begin
						$error("heading_centideg: expected %0d, actual %0d", want, got);
						error_count++;
					end
				end
			end
			outstanding <= heading_expected.size();
		end
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned tx, rx;
		// directed: missing markers, equal rows, equal columns, quadrants, extremes
		add_item(0, 0, 0, 0, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(0, CMAX, CMAX, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, 0, CMAX, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, CMAX, 0, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, CMAX, CMAX, 0, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(3000, 100, 1000, 100, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(1, CMAX, CMAX, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(2048, 2048, 2048, 2048, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, CMAX, CMAX, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(1, 1, 1, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(500, CMAX, 500, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, 1, CMAX, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, 1, 1, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(1, 1, CMAX, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, CMAX, 1, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(1, CMAX, CMAX, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(2, 1, 1, CMAX, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(CMAX, 1, 1, 2, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(1, 2, CMAX, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(2, CMAX, 1, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(2, 1, 1, 2, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(1, 2, 2, 1, IDLE_NONE, IDLE_NONE, 0, 0);
		add_item(12'hAAA, 12'h555, 12'h555, 12'hAAA, IDLE_NONE, IDLE_NONE, 0, 0);

		// random: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				tx = (ph == 1) ? IDLE_HEAVY : (ph == 3) ? IDLE_LIGHT : IDLE_NONE;
				rx = (ph == 2) ? IDLE_HEAVY : (ph == 3) ? IDLE_LIGHT : IDLE_NONE;
				if ((n % 100) < 15) begin
					tx = IDLE_NONE;
					rx = IDLE_NONE;
				end
				add_random(tx, rx, (n == 0) || (n == 230),
					(ph == 0 && n == 100) || (ph == 3 && n == 200));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (coord_fifo.size() != 0 || s_tvalid)
			@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0 && heading_expected.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
